// ===== design/per_host_sequence_number_guard_defines.svh =====
// Assertion macros used by the checker file of the sequence number guard.
`ifndef PER_HOST_SEQUENCE_NUMBER_GUARD_DEFINES_SVH
`define PER_HOST_SEQUENCE_NUMBER_GUARD_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PHSG_ASSERT_IMPL(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("phsg check failed: same-cycle rule");

// Next-cycle implication, disabled during reset.
`define PHSG_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("phsg check failed: next-cycle rule");

`endif

// ===== design/phsg_pkg.sv =====
// Types and constants of the per-host sequence number guard.
`timescale 1ns / 1ps
package phsg_pkg;

    localparam int HOST_W         = 5;
    localparam int HOST_ADDR_SPAN = 2 ** HOST_W;
    localparam int SEQ_W          = 16;
    localparam int CNT_W          = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    localparam logic [1:0] ACT_TRANSMIT      = 2'd0;
    localparam logic [1:0] ACT_VERIFY        = 2'd1;
    localparam logic [1:0] ACT_RESYNC_ANSWER = 2'd2;
    localparam logic [1:0] ACT_RESYNC_APPLY  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESYNC_LIMIT  = 2'd1;

    localparam logic [SEQ_W-1:0] ACCEPT_WINDOW_RESET = 16'd16;
    localparam logic [CNT_W-1:0] RESYNC_LIMIT_RESET  = 8'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [HOST_W-1:0] host;
        logic [SEQ_W-1:0]  seq_a;
        logic [SEQ_W-1:0]  seq_b;
    } t_in_item;

    typedef struct packed {
        logic             status;
        logic             resync_request;
        logic [SEQ_W-1:0] seq_out_a;
        logic [SEQ_W-1:0] seq_out_b;
    } t_out_item;

    typedef struct packed {
        logic [SEQ_W-1:0] rx;
        logic [SEQ_W-1:0] tx;
        logic [CNT_W-1:0] rejects;
    } t_entry;

endpackage

// ===== design/phsg_update.sv =====
// Per-host counter update and result forming for one item.
`timescale 1ns / 1ps
module phsg_update
    import phsg_pkg::*;
(
    input  t_in_item         i_item,
    input  t_entry           i_entry,
    input  logic [SEQ_W-1:0] i_accept_window,
    input  logic [CNT_W-1:0] i_resync_limit,
    output t_entry           o_entry,
    output t_out_item        o_result
);

    logic [SEQ_W:0]   win_end;
    logic             in_window;
    logic [CNT_W-1:0] rejects_inc;
    logic             limit_hit;

    // Window end is kept at full width so it never wraps.
    assign win_end     = {1'b0, i_entry.rx} + {1'b0, i_accept_window};
    assign in_window   = (i_item.seq_a >= i_entry.rx) && ({1'b0, i_item.seq_a} < win_end);
    assign rejects_inc = i_entry.rejects + CNT_W'(1);
    assign limit_hit   = rejects_inc >= i_resync_limit;

    always_comb begin
        o_entry  = i_entry;
        o_result = '0;
        case (i_item.action)
            ACT_TRANSMIT: begin
                o_entry.tx         = i_entry.tx + SEQ_W'(1);
                o_result.seq_out_a = i_entry.tx;
            end
            ACT_VERIFY: begin
                if (in_window) begin
                    o_entry.rejects = '0;
                    o_entry.rx      = i_entry.rx + SEQ_W'(1);
                end else if (limit_hit) begin
                    o_entry.rejects         = '0;
                    o_result.status         = 1'b1;
                    o_result.resync_request = 1'b1;
                    o_result.seq_out_a      = i_entry.rx;
                    o_result.seq_out_b      = i_entry.tx;
                end else begin
                    o_entry.rejects = rejects_inc;
                    o_result.status = 1'b1;
                end
            end
            ACT_RESYNC_ANSWER: begin
                o_entry.tx = (i_item.seq_a > i_entry.tx) ? i_item.seq_a : i_entry.tx;
                o_entry.rx = (i_item.seq_b > i_entry.rx) ? i_item.seq_b : i_entry.rx;
                o_result.seq_out_a = o_entry.tx;
                o_result.seq_out_b = o_entry.rx;
            end
            ACT_RESYNC_APPLY: begin
                o_entry.rx = (i_item.seq_a >= i_entry.rx) ? i_item.seq_a : i_entry.rx;
                o_entry.tx = (i_item.seq_b >= i_entry.tx) ? i_item.seq_b : i_entry.tx;
                o_result.seq_out_a = o_entry.rx;
                o_result.seq_out_b = o_entry.tx;
            end
            default: begin
                o_entry  = i_entry;
                o_result = '0;
            end
        endcase
    end

endmodule

// ===== design/per_host_sequence_number_guard.sv =====
// Top level of the per-host sequence number guard.
//
//   channel  direction  handshake                 payload
//   in       to block   i_in_valid / o_in_stall   i_in_item  (t_in_item)
//   out      from block o_out_valid / i_out_stall o_out_item (t_out_item)
//   cfg      to block   i_cfg_we                  i_cfg_index, i_cfg_data
//
// One item per cycle while no result is stalled; a taken item waits in the input
// register, then its result is offered from the result register. The counter
// table is read and updated while the item is in the input register and written
// back as its result is registered, so items back to back on the same host see
// each other's updates. Reset clears every counter at once.
// A stalled result holds the result register; the input register then fills
// and o_in_stall rises.
`timescale 1ns / 1ps
module per_host_sequence_number_guard
    import phsg_pkg::*;
#(
    parameter int HOST_COUNT = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Only hosts the address field can reach get an entry.
    localparam int DEPTH = (HOST_COUNT < HOST_ADDR_SPAN) ? HOST_COUNT : HOST_ADDR_SPAN;
    localparam int IDX_W = $clog2(DEPTH);

    logic             r_in_valid;
    t_in_item         r_in;
    logic             r_out_valid;
    t_out_item        r_out;
    logic [SEQ_W-1:0] r_accept_window;
    logic [CNT_W-1:0] r_resync_limit;
    t_entry           r_tab [DEPTH];

    logic             advance;
    logic             in_take;
    logic             in_range;
    logic [IDX_W-1:0] idx;
    t_entry           cur_entry;
    t_entry           upd_entry;
    t_out_item        upd_result;
    t_out_item        n_out;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    assign in_range  = 32'(r_in.host) < 32'(HOST_COUNT);
    assign idx       = r_in.host[IDX_W-1:0];
    assign cur_entry = r_tab[idx];

    phsg_update u_update (
        .i_item          (r_in),
        .i_entry         (cur_entry),
        .i_accept_window (r_accept_window),
        .i_resync_limit  (r_resync_limit),
        .o_entry         (upd_entry),
        .o_result        (upd_result)
    );

    always_comb begin
        if (in_range) begin
            n_out = upd_result;
        end else begin
            n_out        = '0;
            n_out.status = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_window <= ACCEPT_WINDOW_RESET;
            r_resync_limit  <= RESYNC_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ACCEPT_WINDOW: r_accept_window <= i_cfg_data[SEQ_W-1:0];
                REG_RESYNC_LIMIT:  r_resync_limit  <= i_cfg_data[CNT_W-1:0];
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_tab[i] <= '0;
            end
        end else if (advance && in_range) begin
            r_tab[idx] <= upd_entry;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== design/phsg_checker.sv =====
// Port-level checks of the sequence number guard and their binding.
`timescale 1ns / 1ps
`include "per_host_sequence_number_guard_defines.svh"
module phsg_checker
    import phsg_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    logic out_held;
    logic req_out;
    logic plain_reject;
    logic seq_zero;

    assign out_held     = o_out_valid && i_out_stall;
    assign req_out      = o_out_valid && o_out_item.resync_request;
    assign plain_reject = o_out_valid && o_out_item.status && !o_out_item.resync_request;
    assign seq_zero     = (o_out_item.seq_out_a == '0) && (o_out_item.seq_out_b == '0);

    // hold a stalled result
    `PHSG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(o_out_item))
    // the input side only backs up behind a waiting result
    `PHSG_ASSERT_IMPL(a_stall_needs_result, i_clk, i_rst_n, !o_out_valid, !o_in_stall)
    // a resync request always comes with a rejection
    `PHSG_ASSERT_IMPL(a_req_is_reject, i_clk, i_rst_n, req_out, o_out_item.status)
    // a plain rejection carries no counters
    `PHSG_ASSERT_IMPL(a_reject_quiet, i_clk, i_rst_n, plain_reject, seq_zero)

endmodule

bind per_host_sequence_number_guard phsg_checker u_phsg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

// ===== dv/per_host_sequence_number_guard_tb.sv =====
// Self-checking testbench of the per-host sequence number guard: directed table, then random items.
`timescale 1ns / 1ps
module per_host_sequence_number_guard_tb;
    import phsg_pkg::*;

    localparam int HOSTS          = 32;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 200;
    localparam int HOLD_CYCLES    = 80;
    localparam int HOLD_PERIOD    = 2500;
    localparam int PRINT_CAP      = 50;

    // Indexes that address no register; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_in_item              it;
        bit                    lit;
        t_out_item             res;
    } t_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_item   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Typed-in result travelling alongside the item on offer.
    bit        lit_pending = 1'b0;
    t_out_item lit_value   = '0;

    // Shadow of the block's counter table and registers.
    logic [SEQ_W-1:0] rx_tab  [HOSTS];
    logic [SEQ_W-1:0] tx_tab  [HOSTS];
    logic [CNT_W-1:0] rej_tab [HOSTS];
    logic [SEQ_W-1:0] win_reg;
    logic [CNT_W-1:0] lim_reg;

    t_out_item guard_results_q[$];
    int        err_count     = 0;
    int        items_taken   = 0;
    int        results_seen  = 0;
    int        settings_used = 1;
    int        idle_cycles   = 0;
    bit        no_idle       = 1'b0;

    per_host_sequence_number_guard #(
        .HOST_COUNT(HOSTS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        err_count++;
        if (err_count <= PRINT_CAP) begin
            $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        end
    endtask

    function automatic t_out_item predict_guard(t_in_item it);
        t_out_item        res;
        logic [SEQ_W-1:0] rx;
        logic [SEQ_W-1:0] tx;
        logic [SEQ_W:0]   upper;
        logic [CNT_W-1:0] cnt;
        res = '0;
        if (int'(it.host) >= HOSTS) begin
            res.status = 1'b1;
            return res;
        end
        rx = rx_tab[it.host];
        tx = tx_tab[it.host];
        case (it.action)
            ACT_TRANSMIT: begin
                tx_tab[it.host] = tx + SEQ_W'(1);
                res.seq_out_a   = tx;
            end
            ACT_VERIFY: begin
                // Upper bound kept at 17 bits so the window never wraps.
                upper = {1'b0, rx} + {1'b0, win_reg};
                if (it.seq_a >= rx && {1'b0, it.seq_a} < upper) begin
                    rej_tab[it.host] = '0;
                    rx_tab[it.host]  = rx + SEQ_W'(1);
                end else begin
                    cnt        = rej_tab[it.host] + CNT_W'(1);
                    res.status = 1'b1;
                    if (cnt >= lim_reg) begin
                        rej_tab[it.host]   = '0;
                        res.resync_request = 1'b1;
                        res.seq_out_a      = rx;
                        res.seq_out_b      = tx;
                    end else begin
                        rej_tab[it.host] = cnt;
                    end
                end
            end
            ACT_RESYNC_ANSWER: begin
                if (it.seq_a > tx) tx = it.seq_a;
                if (it.seq_b > rx) rx = it.seq_b;
                tx_tab[it.host] = tx;
                rx_tab[it.host] = rx;
                res.seq_out_a   = tx;
                res.seq_out_b   = rx;
            end
            default: begin
                if (it.seq_a >= rx) rx = it.seq_a;
                if (it.seq_b >= tx) tx = it.seq_b;
                rx_tab[it.host] = rx;
                tx_tab[it.host] = tx;
                res.seq_out_a   = rx;
                res.seq_out_b   = tx;
            end
        endcase
        return res;
    endfunction

    // Scoreboard: compare results, then log accepted items and register writes.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            foreach (rx_tab[h]) begin
                rx_tab[h]  = '0;
                tx_tab[h]  = '0;
                rej_tab[h] = '0;
            end
            win_reg = ACCEPT_WINDOW_RESET;
            lim_reg = RESYNC_LIMIT_RESET;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (guard_results_q.size() == 0) begin
                    report_mismatch("result with nothing outstanding",
                                    32'(o_out_item.seq_out_a), 0);
                end else begin
                    want = guard_results_q.pop_front();
                    if (o_out_item.status !== want.status)
                        report_mismatch("status", 32'(o_out_item.status), 32'(want.status));
                    if (o_out_item.resync_request !== want.resync_request)
                        report_mismatch("resync_request", 32'(o_out_item.resync_request),
                                        32'(want.resync_request));
                    if (o_out_item.seq_out_a !== want.seq_out_a)
                        report_mismatch("seq_out_a", 32'(o_out_item.seq_out_a),
                                        32'(want.seq_out_a));
                    if (o_out_item.seq_out_b !== want.seq_out_b)
                        report_mismatch("seq_out_b", 32'(o_out_item.seq_out_b),
                                        32'(want.seq_out_b));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                items_taken++;
                want = predict_guard(i_in_item);
                guard_results_q.push_back(lit_pending ? lit_value : want);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ACCEPT_WINDOW: win_reg = i_cfg_data;
                    REG_RESYNC_LIMIT:  lim_reg = i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", idle_cycles);
            $display("FAIL per_host_sequence_number_guard");
            $finish;
        end
    end

    // Receiver: random stall runs, with a long hold-off now and then to back the block up.
    initial begin : out_stall_gen
        int cyc;
        int run_len;
        int next_hold;
        int r;
        bit stall_now;
        cyc       = 0;
        run_len   = 0;
        next_hold = 600;
        stall_now = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            cyc++;
            if (run_len > 0) begin
                run_len--;
            end else if (cyc >= next_hold) begin
                stall_now = 1'b1;
                run_len   = HOLD_CYCLES - 1;
                next_hold = cyc + HOLD_PERIOD;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    stall_now = 1'b0;
                    run_len   = $urandom_range(0, 24);
                end else if (r < 92) begin
                    stall_now = 1'b1;
                    run_len   = $urandom_range(0, 2);
                end else begin
                    stall_now = 1'b1;
                    run_len   = $urandom_range(8, 40);
                end
            end
            i_out_stall <= stall_now;
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic send_item(t_in_item it, bit has_lit, t_out_item lit);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_in_item   <= it;
        lit_pending <= has_lit;
        lit_value   <= lit;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drain: every item yields a result, so an empty queue means the block is idle.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (guard_results_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_row item_row(logic [1:0] act, logic [HOST_W-1:0] h,
                                      logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b,
                                      bit lit = 1'b0, logic st = 1'b0, logic req = 1'b0,
                                      logic [SEQ_W-1:0] oa = '0, logic [SEQ_W-1:0] ob = '0);
        t_row row;
        row.is_cfg             = 1'b0;
        row.idx                = '0;
        row.data               = '0;
        row.it.action          = act;
        row.it.host            = h;
        row.it.seq_a           = a;
        row.it.seq_b           = b;
        row.lit                = lit;
        row.res.status         = st;
        row.res.resync_request = req;
        row.res.seq_out_a      = oa;
        row.res.seq_out_b      = ob;
        return row;
    endfunction

    function automatic t_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_row row;
        row        = item_row(ACT_TRANSMIT, '0, '0, '0);
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        return row;
    endfunction

    // Random item: mostly a few busy hosts, verify numbers near the window edges.
    function automatic t_in_item make_random_item();
        t_in_item         it;
        int               r;
        logic [HOST_W-1:0] h;
        r  = $urandom_range(0, 99);
        h  = (r < 75) ? HOST_W'($urandom_range(0, 3)) : HOST_W'($urandom_range(0, HOSTS - 1));
        it.host  = h;
        it.seq_a = SEQ_W'($urandom);
        it.seq_b = SEQ_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 25) begin
            it.action = ACT_TRANSMIT;
        end else if (r < 75) begin
            it.action = ACT_VERIFY;
            r = $urandom_range(0, 99);
            if (r < 65) begin
                it.seq_a = rx_tab[h] +
                           SEQ_W'($urandom_range(0, (win_reg == 0) ? 0 : int'(win_reg) - 1));
            end else if (r < 75) begin
                it.seq_a = rx_tab[h] + win_reg;
            end else if (r < 85) begin
                it.seq_a = rx_tab[h] - SEQ_W'(1);
            end
        end else begin
            it.action = ($urandom_range(0, 1) == 0) ? ACT_RESYNC_ANSWER : ACT_RESYNC_APPLY;
            if ($urandom_range(0, 1) == 0) begin
                // Peer values close to ours so both sides of each max are hit.
                if (it.action == ACT_RESYNC_ANSWER) begin
                    it.seq_a = tx_tab[h] + SEQ_W'($urandom_range(0, 8)) - 16'd4;
                    it.seq_b = rx_tab[h] + SEQ_W'($urandom_range(0, 8)) - 16'd4;
                end else begin
                    it.seq_a = rx_tab[h] + SEQ_W'($urandom_range(0, 8)) - 16'd4;
                    it.seq_b = tx_tab[h] + SEQ_W'($urandom_range(0, 8)) - 16'd4;
                end
            end
        end
        return it;
    endfunction

    initial begin : main_seq
        t_row             plan[$];
        logic [SEQ_W-1:0] win_set [PHASES];
        logic [CNT_W-1:0] lim_set [PHASES];
        t_out_item        none;
        none = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Counters start at zero, window 16, limit 3.
        plan.push_back(item_row(ACT_TRANSMIT, 5'd0,  16'h0000, 16'h0000, 1, 0, 0, 16'h0000, 16'h0));
        plan.push_back(item_row(ACT_TRANSMIT, 5'd0,  16'hFFFF, 16'hFFFF, 1, 0, 0, 16'h0001, 16'h0));
        plan.push_back(item_row(ACT_TRANSMIT, 5'd31, 16'hFFFF, 16'hFFFF, 1, 0, 0, 16'h0000, 16'h0));
        plan.push_back(item_row(ACT_VERIFY,   5'd1,  16'd0,    16'h0000, 1));
        plan.push_back(item_row(ACT_VERIFY,   5'd1,  16'd16,   16'hFFFF, 1));
        plan.push_back(item_row(ACT_VERIFY,   5'd1,  16'd18,   16'h0000, 1, 1));
        plan.push_back(item_row(ACT_VERIFY,   5'd1,  16'd1,    16'h0000, 1, 1));
        plan.push_back(item_row(ACT_VERIFY,   5'd1,  16'hFFFF, 16'h0000, 1, 1, 1, 16'd2, 16'd0));
        plan.push_back(item_row(ACT_VERIFY,   5'd1,  16'd2,    16'h0000, 1));
        plan.push_back(item_row(ACT_RESYNC_ANSWER, 5'd2, 16'h1234, 16'h0042,
                                1, 0, 0, 16'h1234, 16'h0042));
        plan.push_back(item_row(ACT_RESYNC_ANSWER, 5'd2, 16'h0010, 16'hFFFF,
                                1, 0, 0, 16'h1234, 16'hFFFF));
        // Top of the counter: the window sum must not wrap, the counter must.
        plan.push_back(item_row(ACT_VERIFY,   5'd2,  16'hFFFF, 16'h0000, 1));
        plan.push_back(item_row(ACT_VERIFY,   5'd2,  16'h0000, 16'h0000));
        plan.push_back(item_row(ACT_RESYNC_APPLY, 5'd3, 16'd5,  16'd7, 1, 0, 0, 16'd5, 16'd7));
        plan.push_back(item_row(ACT_RESYNC_APPLY, 5'd3, 16'd4,  16'd7, 1, 0, 0, 16'd5, 16'd7));
        plan.push_back(item_row(ACT_RESYNC_APPLY, 5'd3, 16'hFFFF, 16'd0,
                                1, 0, 0, 16'hFFFF, 16'd7));
        plan.push_back(item_row(ACT_RESYNC_ANSWER, 5'd4, 16'hFFFF, 16'hFFFF,
                                1, 0, 0, 16'hFFFF, 16'hFFFF));
        plan.push_back(item_row(ACT_TRANSMIT, 5'd4,  16'h0000, 16'h0000, 1, 0, 0, 16'hFFFF, 16'h0));
        plan.push_back(item_row(ACT_TRANSMIT, 5'd4,  16'h0000, 16'h0000, 1, 0, 0, 16'h0000, 16'h0));
        // Zero window and zero limit; spare indexes must leave both alone.
        plan.push_back(cfg_row(REG_ACCEPT_WINDOW, 16'h0000));
        plan.push_back(cfg_row(REG_RESYNC_LIMIT,  16'hFF00));
        plan.push_back(cfg_row(REG_SPARE_A,       16'hFFFF));
        plan.push_back(cfg_row(REG_SPARE_B,       16'h5A5A));
        plan.push_back(item_row(ACT_VERIFY,   5'd6,  16'h0000, 16'h0000, 1, 1, 1, 16'd0, 16'd0));
        plan.push_back(item_row(ACT_VERIFY,   5'd0,  16'h0000, 16'h0000, 1, 1, 1, 16'd0, 16'd2));
        // Widest window, highest limit.
        plan.push_back(cfg_row(REG_ACCEPT_WINDOW, 16'hFFFF));
        plan.push_back(cfg_row(REG_RESYNC_LIMIT,  16'hABFF));
        plan.push_back(item_row(ACT_VERIFY,   5'd7,  16'hFFFE, 16'h0000, 1));
        plan.push_back(item_row(ACT_VERIFY,   5'd7,  16'hFFFF, 16'h0000, 1));
        plan.push_back(item_row(ACT_VERIFY,   5'd7,  16'h0001, 16'h0000));

        foreach (plan[n]) begin
            if (plan[n].is_cfg) begin
                settle();
                write_reg(plan[n].idx, plan[n].data);
                settings_used++;
            end else begin
                send_item(plan[n].it, plan[n].lit, plan[n].res);
            end
        end

        win_set = '{16'd1, 16'd16, 16'hFFFF, 16'd0, SEQ_W'($urandom_range(2, 300)), 16'd4};
        lim_set = '{8'd1, 8'd3, 8'd255, 8'd0, CNT_W'($urandom_range(1, 255)), 8'd2};
        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_reg(REG_ACCEPT_WINDOW, win_set[p]);
            write_reg(REG_RESYNC_LIMIT, {CNT_W'($urandom), lim_set[p]});
            write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B,
                      CFG_DATA_W'($urandom));
            settings_used++;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
                send_item(make_random_item(), 1'b0, none);
            end
        end

        settle();
        repeat (10) @(posedge i_clk);

        $display("run covered %0d items and %0d results over %0d register settings",
                 items_taken, results_seen, settings_used);
        $display("%0d field mismatches, %0d results still outstanding",
                 err_count, guard_results_q.size());
        if (err_count == 0 && guard_results_q.size() == 0) begin
            $display("PASS per_host_sequence_number_guard");
        end else begin
            $display("FAIL per_host_sequence_number_guard");
        end
        $finish;
    end

endmodule

// ===== per_host_sequence_number_guard.f =====
+incdir+design
design/phsg_pkg.sv
design/phsg_update.sv
design/per_host_sequence_number_guard.sv
design/phsg_checker.sv
dv/per_host_sequence_number_guard_tb.sv
